// ===== rtl/mpd_pkg.sv =====
package mpd_pkg;

	// frame type codes
	localparam logic [7:0] TYPE_ECG = 8'h08;
	localparam logic [7:0] TYPE_MIN = 8'h09;
	localparam logic [7:0] TYPE_MAX = 8'h1A;

	// byte masks
	localparam logic [7:0] TOP_BIT = 8'h80;
	localparam logic [7:0] LOW7    = 8'h7F;

	// ECG frame: 7 data bytes, the first 6 form three 16-bit words
	localparam int ECG_LEN   = 7;
	localparam int ECG_WORDS = 6;

	// divide by 3: q = (m * 43691) >> 17, exact for m < 2^17
	localparam int          DIV3_SHIFT = 17;
	localparam logic [16:0] DIV3_RECIP = 17'd43691;

	// receive phase codes
	localparam logic [1:0] PH_TYPE = 2'd0;
	localparam logic [1:0] PH_HEAD = 2'd1;
	localparam logic [1:0] PH_DATA = 2'd2;
	localparam logic [1:0] PH_CHK  = 2'd3;

	typedef logic [7:0] byte_t;

endpackage

// ===== rtl/monitor_packet_deframer.sv =====
// Deframer for a patient monitor byte stream. One received byte is taken per
// transfer on the slave side; a byte with bit 7 clear is a type byte and restarts
// framing (type 8 is an ECG frame of 7 data bytes, types 9 to 26 carry one data
// byte). A head byte supplies bit 7 of each data byte, and a closing checksum byte
// validates the frame. A valid ECG frame yields the average of its three signed
// 16-bit words (truncated toward zero); a valid single-value frame yields its data
// byte. Invalid or abandoned frames yield nothing. The block takes one byte every
// cycle while the result register is free or being emptied: a byte passes an input
// register and then the deframing logic, which loads the result register. Both
// sides stall independently; the input keeps flowing while the result register is
// free or being emptied.
module monitor_packet_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] sample_value (signed)
	output logic [4:0]  m_axis_tuser    // [4:0] frame_type
);
	import mpd_pkg::*;

	// input stage
	logic  in_valid_s1;
	byte_t in_byte_s1;

	// frame state
	logic [1:0] phase_q;
	logic [4:0] kind_q;
	logic [6:0] head_q;
	logic [2:0] idx_q;
	byte_t      data_q [ECG_WORDS];

	// result register
	logic        res_valid_q;
	logic [4:0]  res_type_q;
	logic [15:0] res_value_q;

	logic advance;
	logic work;

	assign advance       = !res_valid_q || m_axis_tready;
	assign s_axis_tready = !in_valid_s1 || advance;
	assign work          = in_valid_s1 && advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready) begin
			in_byte_s1 <= s_axis_tdata;
		end
	end

	// ECG sum and divide by 3
	logic signed [17:0] sum;
	logic        [16:0] mag;
	logic        [33:0] prod;
	logic        [15:0] quo;
	logic        [15:0] avg;

	always_comb begin
		sum  = 18'(signed'({data_q[0], data_q[1]}))
		     + 18'(signed'({data_q[2], data_q[3]}))
		     + 18'(signed'({data_q[4], data_q[5]}));
		mag  = sum[17] ? 17'(-sum) : sum[16:0];
		prod = mag * DIV3_RECIP;
		quo  = prod[DIV3_SHIFT +: 16];
		avg  = sum[17] ? 16'(-quo) : quo;
	end

	// deframing decisions
	logic       is_type;
	logic       type_ok;
	logic       is_ecg;
	logic [1:0] cur_phase;
	logic [1:0] phase_d;
	logic       emit;
	byte_t      data_byte;

	always_comb begin
		is_type   = (in_byte_s1 & TOP_BIT) == 8'h00;
		type_ok   = (in_byte_s1 == TYPE_ECG)
		         || (in_byte_s1 >= TYPE_MIN && in_byte_s1 <= TYPE_MAX);
		is_ecg    = {3'b000, kind_q} == TYPE_ECG;
		cur_phase = is_type ? PH_TYPE : phase_q;
		data_byte = {head_q[idx_q], in_byte_s1[6:0]};
		phase_d   = cur_phase;
		emit      = 1'b0;
		unique case (cur_phase)
			PH_TYPE: begin
				if (type_ok) begin
					phase_d = PH_HEAD;
				end
			end
			PH_HEAD: begin
				phase_d = PH_DATA;
			end
			PH_DATA: begin
				if (!is_ecg || idx_q == 3'(ECG_LEN - 1)) begin
					phase_d = PH_CHK;
				end
			end
			PH_CHK: begin
				phase_d = PH_TYPE;
				if (is_ecg) begin
					emit = sum[7:0] == (in_byte_s1 & LOW7);
				end else begin
					emit = (data_q[0] | TOP_BIT) == in_byte_s1;
				end
			end
			default: begin
				phase_d = PH_TYPE;
			end
		endcase
	end

	// frame state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TYPE;
			kind_q  <= 5'd0;
			head_q  <= 7'd0;
			idx_q   <= 3'd0;
		end else if (work) begin
			phase_q <= phase_d;
			if (cur_phase == PH_TYPE && type_ok) begin
				kind_q <= in_byte_s1[4:0];
				head_q <= 7'd0;
			end
			if (cur_phase == PH_HEAD) begin
				head_q <= in_byte_s1[6:0];
				idx_q  <= 3'd0;
			end
			if (cur_phase == PH_DATA && is_ecg && idx_q != 3'(ECG_LEN - 1)) begin
				idx_q <= idx_q + 3'd1;
			end
			if (cur_phase == PH_CHK) begin
				idx_q <= 3'd0;
			end
		end
	end

	// data byte store; the seventh ECG byte is never used
	always_ff @(posedge clk) begin
		if (work && cur_phase == PH_DATA) begin
			for (int i = 0; i < ECG_WORDS; i++) begin
				if (idx_q == 3'(i)) begin
					data_q[i] <= data_byte;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= work && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (work && emit) begin
			res_type_q  <= kind_q;
			res_value_q <= is_ecg ? avg : {8'h00, data_q[0]};
		end
	end

	assign m_axis_tvalid = res_valid_q;
	assign m_axis_tdata  = res_value_q;
	assign m_axis_tuser  = res_type_q;

`ifndef SYNTH
	// a free result slot with no input byte leaves no result
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !in_valid_s1) |=> !m_axis_tvalid)
		else $error("result appeared without an input byte");

	// only known frame types are reported
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser == 5'(TYPE_ECG)
			|| (m_axis_tuser >= 5'(TYPE_MIN) && m_axis_tuser <= 5'(TYPE_MAX))))
		else $error("result carries an unknown frame type");

	// data byte counter stays inside the ECG frame
	assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != 3'd7)
		else $error("data byte counter out of range");

	// a new result only follows a checksum byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(work && emit) |-> (phase_q == PH_CHK && !is_type))
		else $error("result emitted outside the checksum phase");
`endif

endmodule
